// ===== rtl/core/scbm_pkg.sv =====
// Shared types and constants for the sound processor bank mapper.
// Holds the bus operation and result source codes and the channel word types.
// No dependencies.
`timescale 1ns / 1ps

package scbm_pkg;

  typedef enum logic [2:0] {
    OP_MEM_RD  = 3'd0,
    OP_MEM_WR  = 3'd1,
    OP_IO_RD   = 3'd2,
    OP_IO_WR   = 3'd3,
    OP_HOST_WR = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    SRC_INTERNAL  = 3'd0,
    SRC_CART      = 3'd1,
    SRC_SND_READ  = 3'd2,
    SRC_SND_WRITE = 3'd3,
    SRC_NONE      = 3'd4
  } src_e;

  localparam int RamBytes = 2048;

  localparam logic [15:0] BankBase   = 16'h8000;
  localparam logic [15:0] Win8kBase  = 16'hC000;
  localparam logic [15:0] Win4kBase  = 16'hE000;
  localparam logic [15:0] Win2kBase  = 16'hF000;
  localparam logic [15:0] RamBase    = 16'hF800;

  localparam logic [7:0] PortCmd     = 8'h00;
  localparam logic [7:0] PortSndLo   = 8'h04;
  localparam logic [7:0] PortSndHi   = 8'h07;
  localparam logic [7:0] PortBankLo  = 8'h08;
  localparam logic [7:0] PortBankHi  = 8'h0B;
  localparam logic [7:0] PortBankNop = 8'h0C;
  localparam logic [4:0] PortNmiOff  = 5'h18;
  localparam logic [3:0] PortReply   = 4'hC;
  localparam logic [7:0] UnmappedRd  = 8'hFF;

  localparam logic [7:0] Bank0Reset = 8'h1E;
  localparam logic [7:0] Bank1Reset = 8'h0E;
  localparam logic [7:0] Bank2Reset = 8'h06;
  localparam logic [7:0] Bank3Reset = 8'h02;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] address;
    logic [7:0]  data;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [2:0]  source;
    logic [21:0] cart_address;
    logic [1:0]  sound_port;
    logic [7:0]  sound_data;
    logic        nmi;
    logic [7:0]  reply_byte;
  } out_word_t;

endpackage

// ===== rtl/core/scbm_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// The read data holds its value while no read is requested.
// No dependencies.
`timescale 1ns / 1ps

module scbm_ram #(
  parameter int Width = 8,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/sound_cpu_bank_mapper_top.sv =====
// Sound processor bank mapper and host mailbox, top level.
// Depends on scbm_pkg and scbm_ram.
//
// Usage: each input word is one sound processor bus access (memory read or
// write, io read or write) or one host command byte. Each accepted word gives
// exactly one output word with the read data or the source of the data, the
// translated cartridge address, sound chip forwarding, the NMI level and the
// current reply latch.
// Both channels use valid/ready. A word can be accepted every cycle while the
// receiver keeps up, a throughput set by the single RAM read port. The result
// passes through the stage-one register, alongside the registered read of the
// local RAM, and then the output register.
// When the receiver stalls, the output register and the RAM stage hold and
// the input stays ready until both are full.
// Reset restores the bank numbers to 0x1E, 0x0E, 0x06, 0x02 and clears the
// latches and NMI state. Local RAM contents are undefined until written.
`timescale 1ns / 1ps

module sound_cpu_bank_mapper_top
  import scbm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  localparam int RamAw = $clog2(RamBytes);

  logic [3:0][7:0] bank_q, bank_d;
  logic [7:0]      cmd_q, cmd_d;
  logic [7:0]      reply_q, reply_d;
  logic            pend_q, pend_d;
  logic            nmien_q, nmien_d;

  logic            s1_valid_q;
  out_word_t       s1_word_q;
  out_word_t       s0_word;
  logic            s1_ram_q;
  logic            out_valid_q;
  out_word_t       out_word_q, out_word_d;

  logic            in_fire;
  logic            s1_adv;
  logic            ram_re;
  logic            ram_we;
  logic [7:0]      ram_rdata;
  logic [15:0]     addr;
  logic [7:0]      port;
  logic [4:0]      p5;
  logic [3:0]      p4;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  assign addr = in_word_i.address;
  assign port = addr[7:0];
  assign p5   = addr[4:0];
  assign p4   = addr[3:0];

  assign ram_re = in_fire && (in_word_i.op == OP_MEM_RD) && (addr >= RamBase);
  assign ram_we = in_fire && (in_word_i.op == OP_MEM_WR) && (addr >= RamBase);

  always_comb begin
    bank_d  = bank_q;
    cmd_d   = cmd_q;
    reply_d = reply_q;
    pend_d  = pend_q;
    nmien_d = nmien_q;
    s0_word = '0;
    s0_word.source = SRC_NONE;
    unique case (in_word_i.op)
      OP_MEM_RD: begin
        s0_word.source = SRC_CART;
        if (addr < BankBase) begin
          s0_word.cart_address = {6'd0, addr};
        end else if (addr < Win8kBase) begin
          s0_word.cart_address = {bank_q[3], addr[13:0]};
        end else if (addr < Win4kBase) begin
          s0_word.cart_address = {1'b0, bank_q[2], addr[12:0]};
        end else if (addr < Win2kBase) begin
          s0_word.cart_address = {2'd0, bank_q[1], addr[11:0]};
        end else if (addr < RamBase) begin
          s0_word.cart_address = {3'd0, bank_q[0], addr[10:0]};
        end else begin
          s0_word.source = SRC_INTERNAL;
        end
      end
      OP_MEM_WR: begin
      end
      OP_IO_RD: begin
        s0_word.source = SRC_INTERNAL;
        if (port == PortCmd) begin
          pend_d = 1'b0;
          s0_word.read_data = cmd_q;
        end else if (port >= PortSndLo && port <= PortSndHi) begin
          s0_word.source     = SRC_SND_READ;
          s0_word.sound_port = port[1:0];
        end else if (port >= PortBankLo && port <= PortBankHi) begin
          bank_d[port[1:0]] = addr[15:8];
        end else if (port == PortBankNop) begin
          s0_word.read_data = 8'd0;
        end else begin
          s0_word.read_data = UnmappedRd;
        end
      end
      OP_IO_WR: begin
        if (p5 >= PortBankLo[4:0] && p5 <= PortBankHi[4:0]) begin
          nmien_d = 1'b1;
        end else if (p5 == PortNmiOff) begin
          nmien_d = 1'b0;
        end
        if (p4 == PortCmd[3:0]) begin
          cmd_d = 8'd0;
        end else if (p4 >= PortSndLo[3:0] && p4 <= PortSndHi[3:0]) begin
          s0_word.source     = SRC_SND_WRITE;
          s0_word.sound_port = p4[1:0];
          s0_word.sound_data = in_word_i.data;
        end else if (p4 == PortReply) begin
          reply_d = in_word_i.data;
        end
      end
      OP_HOST_WR: begin
        cmd_d  = in_word_i.data;
        pend_d = 1'b1;
      end
      default: begin
      end
    endcase
    s0_word.nmi        = nmien_d & pend_d;
    s0_word.reply_byte = reply_d;
  end

  scbm_ram #(
    .Width(8),
    .Depth(RamBytes)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(addr[RamAw-1:0]),
    .wdata_i(in_word_i.data),
    .re_i   (ram_re),
    .raddr_i(addr[RamAw-1:0]),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    out_word_d = s1_word_q;
    if (s1_ram_q) begin
      out_word_d.read_data = ram_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q      <= {Bank3Reset, Bank2Reset, Bank1Reset, Bank0Reset};
      cmd_q       <= '0;
      reply_q     <= '0;
      pend_q      <= 1'b0;
      nmien_q     <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        bank_q  <= bank_d;
        cmd_q   <= cmd_d;
        reply_q <= reply_d;
        pend_q  <= pend_d;
        nmien_q <= nmien_d;
      end
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_word_q <= s0_word;
      s1_ram_q  <= ram_re;
    end
    if (s1_adv) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ===== sim/sound_cpu_bank_mapper_top_test.sv =====
// Self-checking testbench for the sound processor bank mapper and host mailbox.
// Runs a directed table, then random words; checks each result against the table
// or a behavioral predictor. Depends on scbm_pkg and sound_cpu_bank_mapper_top.
`timescale 1ns / 1ps

module sound_cpu_bank_mapper_top_test;
  import scbm_pkg::*;

  localparam logic [2:0] OpUnusedLo = 3'd5;
  localparam logic [2:0] OpUnusedHi = 3'd7;
  localparam int RandomPerPhase = 367;

  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t want;
  } dir_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  logic [7:0]  bank_num [4];
  logic [7:0]  cmd_latch;
  logic [7:0]  reply_latch;
  logic        nmi_pend;
  logic        nmi_en;
  logic [7:0]  ram_copy [2048];
  bit          ram_valid [2048];
  logic [10:0] ram_filled [$];

  out_word_t expected_words [$];
  dir_row_t  dir_rows [$];
  int        send_idle = 24;
  int        recv_idle = 56;
  int        mismatches = 0;
  int        words_sent = 0;
  int        results_checked = 0;
  int        ram_reads = 0;

  sound_cpu_bank_mapper_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word)
  );

  always #2 clk_i = ~clk_i;

  task automatic predict_bus_access(input in_word_t w, output out_word_t r);
    logic [15:0] a;
    logic [7:0]  port;
    logic [4:0]  p5;
    logic [3:0]  p4;
    a = w.address;
    port = a[7:0];
    p5 = a[4:0];
    p4 = a[3:0];
    r = '0;
    r.source = SRC_NONE;
    case (w.op)
      OP_MEM_RD: begin
        r.source = SRC_CART;
        if (a < BankBase) begin
          r.cart_address = 22'(a);
        end else if (a < Win8kBase) begin
          r.cart_address = (22'(bank_num[3]) << 14) | 22'(a[13:0]);
        end else if (a < Win4kBase) begin
          r.cart_address = (22'(bank_num[2]) << 13) | 22'(a[12:0]);
        end else if (a < Win2kBase) begin
          r.cart_address = (22'(bank_num[1]) << 12) | 22'(a[11:0]);
        end else if (a < RamBase) begin
          r.cart_address = (22'(bank_num[0]) << 11) | 22'(a[10:0]);
        end else begin
          r.source = SRC_INTERNAL;
          r.read_data = ram_copy[a[10:0]];
          ram_reads++;
        end
      end
      OP_MEM_WR: begin
        if (a >= RamBase) begin
          ram_copy[a[10:0]] = w.data;
          if (!ram_valid[a[10:0]]) begin
            ram_valid[a[10:0]] = 1'b1;
            ram_filled.push_back(a[10:0]);
          end
        end
      end
      OP_IO_RD: begin
        r.source = SRC_INTERNAL;
        if (port == PortCmd) begin
          nmi_pend = 1'b0;
          r.read_data = cmd_latch;
        end else if (port >= PortSndLo && port <= PortSndHi) begin
          r.source = SRC_SND_READ;
          r.sound_port = port[1:0];
        end else if (port >= PortBankLo && port <= PortBankHi) begin
          bank_num[port[1:0]] = a[15:8];
        end else if (port != PortBankNop) begin
          r.read_data = UnmappedRd;
        end
      end
      OP_IO_WR: begin
        if (p5 >= PortBankLo[4:0] && p5 <= PortBankHi[4:0]) begin
          nmi_en = 1'b1;
        end else if (p5 == PortNmiOff) begin
          nmi_en = 1'b0;
        end
        if (p4 == PortCmd[3:0]) begin
          cmd_latch = '0;
        end else if (p4 >= PortSndLo[3:0] && p4 <= PortSndHi[3:0]) begin
          r.source = SRC_SND_WRITE;
          r.sound_port = p4[1:0];
          r.sound_data = w.data;
        end else if (p4 == PortReply) begin
          reply_latch = w.data;
        end
      end
      OP_HOST_WR: begin
        cmd_latch = w.data;
        nmi_pend = 1'b1;
      end
      default: ;
    endcase
    r.nmi = nmi_en & nmi_pend;
    r.reply_byte = reply_latch;
  endtask

  task automatic drive_word(input in_word_t w, input bit typed, input out_word_t typed_want);
    out_word_t want;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk_i); while (!in_ready);
    predict_bus_access(w, want);
    expected_words.push_back(typed ? typed_want : want);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic build_random_word(output in_word_t w);
    int          pick;
    logic [15:0] a;
    pick = $urandom_range(0, 99);
    a = 16'($urandom);
    w.data = 8'($urandom);
    if (pick < 38) begin
      w.op = OP_MEM_RD;
      if (ram_filled.size() > 0 && $urandom_range(0, 2) == 0) begin
        a = RamBase | 16'(ram_filled[$urandom_range(0, ram_filled.size() - 1)]);
      end else if (a >= RamBase && !ram_valid[a[10:0]]) begin
        a[11] = 1'b0;
      end
    end else if (pick < 58) begin
      w.op = OP_MEM_WR;
      if ($urandom_range(0, 9) < 7) a = a | RamBase;
    end else if (pick < 73) begin
      w.op = OP_IO_RD;
      if ($urandom_range(0, 4) != 0) a[7:0] = 8'($urandom_range(0, PortBankNop));
    end else if (pick < 88) begin
      w.op = OP_IO_WR;
    end else if (pick < 96) begin
      w.op = OP_HOST_WR;
    end else begin
      w.op = 3'($urandom_range(OpUnusedLo, OpUnusedHi));
    end
    w.address = a;
  endtask

  task automatic report_mismatch(input string what, input longint got_v, input longint want_v);
    $display("MISMATCH at result %0d, %s: got 0x%0h, expected 0x%0h",
             results_checked, what, got_v, want_v);
    mismatches++;
  endtask

  task automatic check_result(input out_word_t got);
    out_word_t want;
    if (expected_words.size() == 0) begin
      report_mismatch("word with nothing expected", got, 0);
      return;
    end
    want = expected_words.pop_front();
    results_checked++;
    if (got.read_data !== want.read_data)
      report_mismatch("read_data", got.read_data, want.read_data);
    if (got.source !== want.source)
      report_mismatch("source", got.source, want.source);
    if (got.cart_address !== want.cart_address)
      report_mismatch("cart_address", got.cart_address, want.cart_address);
    if (got.sound_port !== want.sound_port)
      report_mismatch("sound_port", got.sound_port, want.sound_port);
    if (got.sound_data !== want.sound_data)
      report_mismatch("sound_data", got.sound_data, want.sound_data);
    if (got.nmi !== want.nmi)
      report_mismatch("nmi", got.nmi, want.nmi);
    if (got.reply_byte !== want.reply_byte)
      report_mismatch("reply_byte", got.reply_byte, want.reply_byte);
  endtask

  always @(negedge clk_i) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    if (out_valid && out_ready) check_result(out_word);
  end

  initial begin
    #400us;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    in_word_t w;
    bank_num[0] = Bank0Reset;
    bank_num[1] = Bank1Reset;
    bank_num[2] = Bank2Reset;
    bank_num[3] = Bank3Reset;
    cmd_latch = '0;
    reply_latch = '0;
    nmi_pend = 1'b0;
    nmi_en = 1'b0;

    dir_rows.push_back('{'{OP_MEM_RD, 16'h0000, 8'h00}, 1'b1,
                         '{8'h00, SRC_CART, 22'h000000, 2'd0, 8'h00, 1'b0, 8'h00}});
    dir_rows.push_back('{'{OP_MEM_RD, 16'h7FFF, 8'hFF}, 1'b1,
                         '{8'h00, SRC_CART, 22'h007FFF, 2'd0, 8'h00, 1'b0, 8'h00}});
    dir_rows.push_back('{'{OP_MEM_RD, 16'h8000, 8'h00}, 1'b1,
                         '{8'h00, SRC_CART, 22'h008000, 2'd0, 8'h00, 1'b0, 8'h00}});
    dir_rows.push_back('{'{OP_MEM_RD, 16'hC000, 8'h00}, 1'b1,
                         '{8'h00, SRC_CART, 22'h00C000, 2'd0, 8'h00, 1'b0, 8'h00}});
    dir_rows.push_back('{'{OP_MEM_RD, 16'hE000, 8'h00}, 1'b1,
                         '{8'h00, SRC_CART, 22'h00E000, 2'd0, 8'h00, 1'b0, 8'h00}});
    dir_rows.push_back('{'{OP_MEM_RD, 16'hF7FF, 8'h00}, 1'b1,
                         '{8'h00, SRC_CART, 22'h00F7FF, 2'd0, 8'h00, 1'b0, 8'h00}});
    dir_rows.push_back('{'{OP_MEM_WR, 16'hF800, 8'hA5}, 1'b1,
                         '{8'h00, SRC_NONE, 22'h000000, 2'd0, 8'h00, 1'b0, 8'h00}});
    dir_rows.push_back('{'{OP_MEM_WR, 16'hFFFF, 8'h5A}, 1'b1,
                         '{8'h00, SRC_NONE, 22'h000000, 2'd0, 8'h00, 1'b0, 8'h00}});
    dir_rows.push_back('{'{OP_MEM_RD, 16'hF800, 8'h00}, 1'b1,
                         '{8'hA5, SRC_INTERNAL, 22'h000000, 2'd0, 8'h00, 1'b0, 8'h00}});
    dir_rows.push_back('{'{OP_MEM_RD, 16'hFFFF, 8'h00}, 1'b1,
                         '{8'h5A, SRC_INTERNAL, 22'h000000, 2'd0, 8'h00, 1'b0, 8'h00}});
    dir_rows.push_back('{'{OP_MEM_WR, 16'h1234, 8'h77}, 1'b1,
                         '{8'h00, SRC_NONE, 22'h000000, 2'd0, 8'h00, 1'b0, 8'h00}});
    dir_rows.push_back('{'{OP_IO_RD, 16'hFF08, 8'h00}, 1'b1,
                         '{8'h00, SRC_INTERNAL, 22'h000000, 2'd0, 8'h00, 1'b0, 8'h00}});
    dir_rows.push_back('{'{OP_IO_RD, 16'h00FF, 8'h00}, 1'b1,
                         '{8'hFF, SRC_INTERNAL, 22'h000000, 2'd0, 8'h00, 1'b0, 8'h00}});
    dir_rows.push_back('{'{OP_MEM_RD, 16'hF7FF, 8'h00}, 1'b0, '0});
    dir_rows.push_back('{'{OP_IO_RD, 16'h800B, 8'h00}, 1'b0, '0});
    dir_rows.push_back('{'{OP_MEM_RD, 16'hBFFF, 8'h00}, 1'b0, '0});
    dir_rows.push_back('{'{OP_IO_RD, 16'h000C, 8'h00}, 1'b0, '0});
    dir_rows.push_back('{'{OP_IO_RD, 16'h0005, 8'h00}, 1'b0, '0});
    dir_rows.push_back('{'{OP_HOST_WR, 16'h0000, 8'hC3}, 1'b0, '0});
    dir_rows.push_back('{'{OP_IO_WR, 16'h0008, 8'h00}, 1'b0, '0});
    dir_rows.push_back('{'{OP_IO_RD, 16'h0000, 8'h00}, 1'b0, '0});
    dir_rows.push_back('{'{OP_IO_WR, 16'h000C, 8'h99}, 1'b0, '0});
    dir_rows.push_back('{'{OP_IO_WR, 16'hFFE7, 8'hFF}, 1'b0, '0});
    dir_rows.push_back('{'{OP_IO_WR, 16'h0018, 8'h00}, 1'b0, '0});
    dir_rows.push_back('{'{OP_IO_WR, 16'h0010, 8'h00}, 1'b0, '0});
    dir_rows.push_back('{'{OpUnusedHi, 16'hFFFF, 8'hFF}, 1'b0, '0});

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) drive_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].want);

    // Let the block drain completely before the random traffic starts.
    in_valid <= 1'b0;
    wait (expected_words.size() == 0);
    @(negedge clk_i);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 24 : (phase == 1) ? 56 : 0;
      recv_idle = (phase == 0) ? 56 : (phase == 1) ? 24 : 0;
      for (int n = 0; n < RandomPerPhase; n++) begin
        build_random_word(w);
        drive_word(w, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;

    wait (expected_words.size() == 0);
    repeat (8) @(posedge clk_i);

    $display("Ran %0d words (%0d directed) through three idle patterns; %0d results checked,",
             words_sent, dir_rows.size(), results_checked);
    $display("including %0d local RAM reads over %0d written bytes.",
             ram_reads, ram_filled.size());
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sound_cpu_bank_mapper_top.f =====
rtl/core/scbm_pkg.sv
rtl/core/scbm_ram.sv
rtl/core/sound_cpu_bank_mapper_top.sv
sim/sound_cpu_bank_mapper_top_test.sv
